[hw/rtl/page_framebuffer_draw_engine_defines.svh]
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// property that must hold at every edge outside reset
`define PFDE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold at the edge after the antecedent
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/pfde_pkg.sv]
package pfde_pkg;

   localparam int DEF_SCREEN_WIDTH  = 128;
   localparam int DEF_SCREEN_HEIGHT = 64;
   localparam int PAGE_ROWS         = 8;
   localparam int BYTE_BITS         = 8;
   localparam int COL_BITS          = 8;
   localparam int ROW_BITS          = 3;
   localparam int PAGE_BITS         = 5;

   typedef enum logic [2:0] {
      OP_CLEAR     = 3'd0,
      OP_SET_PIXEL = 3'd1,
      OP_GET_PIXEL = 3'd2,
      OP_HLINE     = 3'd3,
      OP_VLINE     = 3'd4,
      OP_FILL_RECT = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_DRAW,
      KIND_READ
   } cmd_kind_type;

   // one command reduced to a clipped byte region
   typedef struct packed {
      cmd_kind_type          kind;
      logic                  color;
      logic [COL_BITS-1:0]   x_lo;
      logic [COL_BITS-1:0]   x_hi;
      logic [PAGE_BITS-1:0]  page_lo;
      logic [PAGE_BITS-1:0]  page_hi;
      logic [ROW_BITS-1:0]   row_lo;
      logic [ROW_BITS-1:0]   row_hi;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic init;
      logic idle;
   } back_status_type;

endpackage

[hw/rtl/pfde_ram.sv]
module pfde_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/pfde_front.sv]
module pfde_front
   import pfde_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [7:0]  req_run_length,
   input  logic [7:0]  req_rect_height,
   input  logic        req_color,
   output desc_type    desc
);

   localparam int PAGES = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);
   localparam logic [COL_BITS-1:0]  X_LAST    = COL_BITS'(SCREEN_WIDTH - 1);
   localparam logic [PAGE_BITS-1:0] PAGE_LAST = PAGE_BITS'(PAGES - 1);

   logic [7:0] w_len;
   logic [7:0] h_len;
   logic [8:0] x_end;
   logic [8:0] y_end;
   logic [8:0] x_lim;
   logic [8:0] y_lim;
   logic [8:0] x_last;
   logic [8:0] y_last;
   logic       in_view;
   desc_type   region;

   always_comb begin
      case (req_opcode)
         OP_HLINE:     begin w_len = req_run_length; h_len = 8'd1;            end
         OP_VLINE:     begin w_len = 8'd1;           h_len = req_run_length;  end
         OP_FILL_RECT: begin w_len = req_run_length; h_len = req_rect_height; end
         default:      begin w_len = 8'd1;           h_len = 8'd1;            end
      endcase

      x_end  = {1'b0, req_pos_x} + {1'b0, w_len};
      y_end  = {1'b0, req_pos_y} + {1'b0, h_len};
      x_lim  = (x_end > WIDTH_LIM)  ? WIDTH_LIM  : x_end;
      y_lim  = (y_end > HEIGHT_LIM) ? HEIGHT_LIM : y_end;
      x_last = x_lim - 9'd1;
      y_last = y_lim - 9'd1;
      in_view = ({1'b0, req_pos_x} < WIDTH_LIM) && ({1'b0, req_pos_y} < HEIGHT_LIM)
                && (w_len != 8'd0) && (h_len != 8'd0);

      region.kind    = KIND_DRAW;
      region.color   = req_color;
      region.x_lo    = req_pos_x;
      region.x_hi    = x_last[COL_BITS-1:0];
      region.page_lo = PAGE_BITS'(req_pos_y >> 3);
      region.page_hi = PAGE_BITS'(y_last >> 3);
      region.row_lo  = req_pos_y[ROW_BITS-1:0];
      region.row_hi  = y_last[ROW_BITS-1:0];

      desc = region;
      unique case (req_opcode) inside
         OP_CLEAR: begin
            desc.color   = 1'b0;
            desc.x_lo    = '0;
            desc.x_hi    = X_LAST;
            desc.page_lo = '0;
            desc.page_hi = PAGE_LAST;
            desc.row_lo  = '0;
            desc.row_hi  = 3'd7;
         end
         OP_SET_PIXEL, OP_HLINE, OP_VLINE, OP_FILL_RECT: begin
            desc.kind = in_view ? KIND_DRAW : KIND_NONE;
         end
         OP_GET_PIXEL: begin
            desc.kind = in_view ? KIND_READ : KIND_NONE;
         end
         default: begin
            desc.kind = KIND_NONE;
         end
      endcase
   end

endmodule

[hw/rtl/pfde_queue.sv]
module pfde_queue
   import pfde_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output desc_type         head_desc,
   output queue_status_type status
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign head_desc    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_desc;
            wr_ptr_ff           <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

[hw/rtl/pfde_back.sv]
module pfde_back
   import pfde_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  desc_type              q_desc,
   input  queue_status_type      q_status,
   output logic                  q_pop,
   output logic                  ram_wr_en,
   output logic [$clog2(SCREEN_WIDTH * ((SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS))-1:0]
                                 ram_wr_addr,
   output logic [BYTE_BITS-1:0]  ram_wr_data,
   output logic [$clog2(SCREEN_WIDTH * ((SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS))-1:0]
                                 ram_rd_addr,
   input  logic [BYTE_BITS-1:0]  ram_rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pixel_value,
   output back_status_type       status
);

   localparam int PAGES = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int DEPTH = SCREEN_WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0]        ROW_STRIDE = AW'(SCREEN_WIDTH);
   localparam logic [COL_BITS-1:0]  X_LAST     = COL_BITS'(SCREEN_WIDTH - 1);
   localparam logic [PAGE_BITS-1:0] PAGE_LAST  = PAGE_BITS'(PAGES - 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type             state_ff;
   desc_type              cur_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [AW-1:0]         base_ff;
   logic                  pend_ff;
   logic [AW-1:0]         wr_addr_ff;
   logic [BYTE_BITS-1:0]  wr_mask_ff;
   logic                  init_ff;
   logic                  result_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_pixel_ff;

   logic [ROW_BITS-1:0]   row_start;
   logic [ROW_BITS-1:0]   row_end;
   logic [BYTE_BITS-1:0]  byte_mask;
   logic [AW-1:0]         rd_addr;

   // rows of the current page that the region covers, top row in the msb
   always_comb begin
      row_start = (page_ff == cur_ff.page_lo) ? cur_ff.row_lo : '0;
      row_end   = (page_ff == cur_ff.page_hi) ? cur_ff.row_hi : 3'd7;
      byte_mask = (8'hFF >> row_start) & (8'hFF << (3'd7 - row_end));
      rd_addr   = base_ff + AW'(col_ff);
   end

   assign q_pop           = (state_ff == S_IDLE) && !q_status.empty;
   assign ram_rd_addr     = rd_addr;
   assign ram_wr_en       = pend_ff && (cur_ff.kind == KIND_DRAW);
   assign ram_wr_addr     = wr_addr_ff;
   assign ram_wr_data     = cur_ff.color ? (ram_rd_data | wr_mask_ff)
                                         : (ram_rd_data & ~wr_mask_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign status.init     = init_ff;
   assign status.idle     = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pend_ff      <= 1'b0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_pixel_ff <= result_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               // clearing pass over the whole store
               cur_ff.kind    <= KIND_DRAW;
               cur_ff.color   <= 1'b0;
               cur_ff.x_lo    <= '0;
               cur_ff.x_hi    <= X_LAST;
               cur_ff.page_lo <= '0;
               cur_ff.page_hi <= PAGE_LAST;
               cur_ff.row_lo  <= '0;
               cur_ff.row_hi  <= 3'd7;
               col_ff         <= '0;
               page_ff        <= '0;
               base_ff        <= '0;
               state_ff       <= S_RUN;
            end
            S_IDLE: begin
               if (!q_status.empty) begin
                  cur_ff    <= q_desc;
                  col_ff    <= q_desc.x_lo;
                  page_ff   <= q_desc.page_lo;
                  base_ff   <= AW'(q_desc.page_lo * SCREEN_WIDTH);
                  result_ff <= 1'b0;
                  state_ff  <= (q_desc.kind == KIND_NONE) ? S_DONE : S_RUN;
               end
            end
            S_RUN: begin
               pend_ff    <= 1'b1;
               wr_addr_ff <= rd_addr;
               wr_mask_ff <= byte_mask;
               if (col_ff == cur_ff.x_hi) begin
                  if (page_ff == cur_ff.page_hi) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     col_ff  <= cur_ff.x_lo;
                     page_ff <= page_ff + PAGE_BITS'(1);
                     base_ff <= base_ff + ROW_STRIDE;
                  end
               end else begin
                  col_ff <= col_ff + COL_BITS'(1);
               end
            end
            S_DRAIN: begin
               pend_ff   <= 1'b0;
               result_ff <= (cur_ff.kind == KIND_READ) && |(ram_rd_data & wr_mask_ff);
               init_ff   <= 1'b0;
               state_ff  <= init_ff ? S_IDLE : S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[hw/rtl/page_framebuffer_draw_engine.sv]
// path from the accepted beat to rsp_valid: queue, S_IDLE, S_RUN for each byte touched,
// S_DRAIN, S_DONE; a command that draws nothing goes from S_IDLE straight to S_DONE
// throughput: one command at a time, one byte per cycle
// a two-entry command queue lets new beats in while the back end draws
// reset: synchronous; afterwards a clearing pass holds req_stall high
// while it zeroes the store
`include "page_framebuffer_draw_engine_defines.svh"

module page_framebuffer_draw_engine
   import pfde_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_run_length,
   input  logic [7:0] req_rect_height,
   input  logic       req_color,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_pixel_value
);

   localparam int PAGES = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int DEPTH = SCREEN_WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);

   desc_type          front_desc;
   desc_type          head_desc;
   queue_status_type  q_status;
   back_status_type   back_status;
   logic              q_push;
   logic              q_pop;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_BITS-1:0] ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_BITS-1:0] ram_rd_data;

   assign req_stall = q_status.full || back_status.init;
   assign q_push    = req_valid && !req_stall;

   pfde_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_run_length  (req_run_length),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .desc            (front_desc)
   );

   pfde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (front_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   pfde_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_desc          (head_desc),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .status          (back_status)
   );

   pfde_ram #(
      .DATA_WIDTH (BYTE_BITS),
      .DEPTH      (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   `PFDE_ASSERT(a_init_holds_req, back_status.init |-> req_stall, "beat taken during clearing pass")
   `PFDE_ASSERT(a_pop_not_empty, q_pop |-> !q_status.empty, "pop from empty command queue")
   `PFDE_ASSERT(a_no_write_idle, back_status.idle |-> !ram_wr_en, "store written while idle")
   `PFDE_ASSERT_NEXT(a_pop_leaves_idle, q_pop, !back_status.idle, "back end stayed idle after pop")

endmodule

[dv/tb_page_framebuffer_draw_engine.sv]
`timescale 1ns / 100ps

module tb_page_framebuffer_draw_engine;
   import pfde_pkg::*;

   localparam int SCR_W = DEF_SCREEN_WIDTH;
   localparam int SCR_H = DEF_SCREEN_HEIGHT;
   localparam int PAGES = (SCR_H + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int FRAME_BYTES = SCR_W * PAGES;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS    = 555;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 1100;
   localparam int TIMEOUT_NS      = 25_000_000;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] len;
      logic [7:0] h;
      logic       color;
      bit         typed;
      logic       want;
   } draw_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam draw_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_GET_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_SET_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b1},
      '{OP_SET_PIXEL, 8'd127, 8'd63,  8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   1'b0, 1'b1, 1'b1},
      '{OP_SET_PIXEL, 8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd128, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{OP_HLINE,     8'd120, 8'd7,   8'd255, 8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd127, 8'd7,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_VLINE,     8'd5,   8'd60,  8'd255, 8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd5,   8'd63,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_HLINE,     8'd10,  8'd10,  8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd10,  8'd10,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_FILL_RECT, 8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd64,  8'd32,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_FILL_RECT, 8'd3,   8'd5,   8'd10,  8'd20,  1'b0, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd4,   8'd6,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_SPARE_A,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{OP_SPARE_B,   8'd1,   8'd2,   8'd3,   8'd4,   1'b0, 1'b1, 1'b0},
      '{OP_CLEAR,     8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_GET_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{OP_FILL_RECT, 8'd20,  8'd20,  8'd5,   8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_VLINE,     8'd30,  8'd30,  8'd0,   8'd9,   1'b1, 1'b1, 1'b0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_opcode = '0;
   logic [7:0] req_pos_x = '0;
   logic [7:0] req_pos_y = '0;
   logic [7:0] req_run_length = '0;
   logic [7:0] req_rect_height = '0;
   logic       req_color = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_pixel_value;

   logic [7:0] frame_bytes [FRAME_BYTES];
   logic       pixel_q [$];
   int         mismatches = 0;
   bit         idle_on = 1'b1;
   bit         hold_off_req = 1'b0;

   page_framebuffer_draw_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_run_length  (req_run_length),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void plot(int x, int y, logic color);
      int addr;
      if (x >= SCR_W || y >= SCR_H) return;
      addr = (y / PAGE_ROWS) * SCR_W + x;
      frame_bytes[addr][7 - (y % PAGE_ROWS)] = color;
   endfunction

   function automatic logic pixel_at(int x, int y);
      if (x >= SCR_W || y >= SCR_H) return 1'b0;
      return frame_bytes[(y / PAGE_ROWS) * SCR_W + x][7 - (y % PAGE_ROWS)];
   endfunction

   function automatic void span_row(int x0, int y, int len, logic color);
      for (int i = 0; i < len && x0 + i < SCR_W; i++) plot(x0 + i, y, color);
   endfunction

   function automatic logic draw_predict(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] len, logic [7:0] h, logic color);
      logic pix;
      pix = 1'b0;
      case (op)
         OP_CLEAR: begin
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
         end
         OP_SET_PIXEL: plot(int'(x), int'(y), color);
         OP_GET_PIXEL: pix = pixel_at(int'(x), int'(y));
         OP_HLINE: if (y < SCR_H) span_row(int'(x), int'(y), int'(len), color);
         OP_VLINE: begin
            for (int i = 0; i < len && y + i < SCR_H; i++) plot(int'(x), int'(y) + i, color);
         end
         OP_FILL_RECT: begin
            for (int r = 0; r < h && y + r < SCR_H; r++)
               span_row(int'(x), int'(y) + r, int'(len), color);
         end
         default: ;
      endcase
      return pix;
   endfunction

   // called at a rising edge; returns at the edge that takes the beat
   task automatic send_cmd(logic [2:0] op, logic [7:0] x, logic [7:0] y, logic [7:0] len,
                           logic [7:0] h, logic color, bit typed, logic want);
      logic got;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_run_length  <= len;
      req_rect_height <= h;
      req_color       <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = draw_predict(op, x, y, len, h, color);
      pixel_q.push_back(typed ? want : got);
   endtask

   initial begin
      int         pick;
      int         last_x;
      int         last_y;
      logic [2:0] op;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] len;
      logic [7:0] h;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      last_x = 0;
      last_y = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++)
         send_cmd(DIRECTED[n].op, DIRECTED[n].x, DIRECTED[n].y, DIRECTED[n].len,
                  DIRECTED[n].h, DIRECTED[n].color, DIRECTED[n].typed, DIRECTED[n].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 60) hold_off_req = 1'b1;
         if (n == RANDOM_ITEMS - 80) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) begin
            x = 8'($urandom_range(0, 255));
            y = 8'($urandom_range(0, 255));
         end else begin
            x = 8'($urandom_range(0, SCR_W + 7));
            y = 8'($urandom_range(0, SCR_H + 7));
         end
         len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 16));
         h = 8'($urandom_range(0, 255));
         if (pick < 2) op = OP_CLEAR;
         else if (pick < 4) op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
         else if (pick < 28) op = OP_SET_PIXEL;
         else if (pick < 58) op = OP_GET_PIXEL;
         else if (pick < 72) op = OP_HLINE;
         else if (pick < 86) op = OP_VLINE;
         else begin
            op = OP_FILL_RECT;
            if ($urandom_range(0, 24) != 0) begin
               len = 8'($urandom_range(0, 12));
               h   = 8'($urandom_range(0, 10));
            end
         end
         // half of the reads land near the last thing drawn
         if (op == OP_GET_PIXEL && $urandom_range(0, 1) == 0) begin
            x = 8'(last_x + $urandom_range(0, 4) - 2);
            y = 8'(last_y + $urandom_range(0, 4) - 2);
         end
         if (op != OP_GET_PIXEL) begin
            last_x = int'(x) + $urandom_range(0, 2);
            last_y = int'(y) + $urandom_range(0, 2);
         end
         send_cmd(op, x, y, len, h, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end
      req_valid <= 1'b0;

      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS page_framebuffer_draw_engine");
      end else begin
         $display("FAIL page_framebuffer_draw_engine");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual pixel %0b",
                     $time, rsp_pixel_value);
            mismatches++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_pixel_value !== want) begin
               $display("%0t: pixel_value expected %0b actual %0b",
                        $time, want, rsp_pixel_value);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL page_framebuffer_draw_engine");
      $finish;
   end

endmodule
